// ----- src/pstk_pkg.sv -----
// Shared types, constants and helpers of the position step and speed tracker.
`default_nettype none
package pstk_pkg;

  localparam int CW          = 14;  // clamped coordinate
  localparam int MSW         = 10;  // max_step register
  localparam int SCW         = 8;   // speed_scale register
  localparam int TW          = 32;  // timestamp
  localparam int TOTW        = 40;  // per-sensor total
  localparam int STEPW       = 20;  // reported step
  localparam int SPDW        = 24;  // reported speed
  localparam int SIDW        = 4;   // sensor id
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 14;
  localparam int SQ_W        = 2 * CW + 1;  // dx*dx + dy*dy

  localparam int NUM_SENSORS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;

  localparam logic [CW-1:0]   COORD_LIMIT_RST = 14'd10000;
  localparam logic [MSW-1:0]  MAX_STEP_RST    = 10'd50;
  localparam logic [SCW-1:0]  SPEED_SCALE_RST = 8'd10;
  localparam logic [SPDW-1:0] SPEED_MAX       = '1;
  localparam logic [TOTW-1:0] TOTAL_MAX       = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COORD_LIMIT = 2'd0,
    CFG_MAX_STEP    = 2'd1,
    CFG_SPEED_SCALE = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MOD, ST_RD, ST_LOAD, ST_SQA, ST_SQB, ST_RTS, ST_RTW,
    ST_NUMX, ST_DVXS, ST_DVXW, ST_NUMY, ST_DVYS, ST_DVYW,
    ST_SPD, ST_SPM, ST_SPS, ST_SPW, ST_TOT, ST_WB, ST_OUT
  } state_t;

  // Clamp a signed raw coordinate to 0..lim.
  function automatic logic [CW-1:0] clamp_coord(input logic [TW-1:0] v,
                                                input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (v[TW-1]) begin
      r = '0;
    end else if (v > {{(TW-CW){1'b0}}, lim}) begin
      r = lim;
    end else begin
      r = v[CW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- src/pstk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pstk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ----- src/pstk_sqrt.sv -----
// Bit-serial integer square root, one root bit per cycle.
`default_nettype none
module pstk_sqrt #(
  parameter int RW = 46
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [RW-1:0]     rad,
  output logic                   done,
  output logic      [RW/2-1:0]   root
);

  localparam int RTW  = RW / 2;
  localparam int CNTW = $clog2(RTW + 1);

  logic [RW-1:0]    rad_r;
  logic [RTW:0]     rem_r;
  logic [RTW-1:0]   root_r;
  logic [CNTW-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [RTW+2:0]   cur;
  logic [RTW+2:0]   tst;
  logic [RTW+2:0]   dif;
  logic             ge;

  // Bring down the next bit pair and try root*4+1.
  assign cur  = {rem_r, rad_r[RW-1:RW-2]};
  assign tst  = {1'b0, root_r, 2'b01};
  assign ge   = cur >= tst;
  assign dif  = cur - tst;
  assign done = done_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(RTW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[RW-3:0], 2'b00};
      rem_r  <= ge ? dif[RTW:0] : cur[RTW:0];
      root_r <= {root_r[RTW-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- src/pstk_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module pstk_div #(
  parameter int DW = 32,
  parameter int SW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [SW-1:0] divisor,
  output logic               done,
  output logic      [DW-1:0] quo,
  output logic               rem_nz
);

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   dvd_r;
  logic [SW-1:0]   dvs_r;
  logic [SW-1:0]   rem_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  logic [SW:0]     cur;
  logic [SW:0]     dif;
  logic            ge;

  assign cur    = {rem_r, dvd_r[DW-1]};
  assign ge     = cur >= {1'b0, dvs_r};
  assign dif    = cur - {1'b0, dvs_r};
  assign done   = done_r;
  assign quo    = dvd_r;
  assign rem_nz = |rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNTW'(DW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the quotient into the dividend register as its bits leave.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DW-2:0], ge};
      rem_r <= ge ? dif[SW-1:0] : cur[SW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- src/position_step_speed_tracker_top.sv -----
// Top level of the position step and speed tracker: control sequencer and datapath.
`default_nettype none
// Each request is a position report of one sensor. The block clamps x and y
// to 0..coord_limit, reads the sensor's last point, time and running total
// from a small RAM, and for an update measures the step length in unsigned
// fixed point with FRAC_BITS fraction bits. A step longer than max_step is
// shrunk toward it and measured again. Speed is step*speed_scale/elapsed,
// saturating; a nonpositive elapsed time with a nonzero step flags
// time_error. One result leaves per request. Requests are handled one at a
// time; a request is taken while the previous result still waits at the
// output. The sensor id is first wrapped into the table by repeated
// subtraction of NUM_SENSORS. The bit-serial root and divide units each
// produce one bit per cycle. An update runs one root and, for a nonzero
// step and positive elapsed time, one speed divide; a shrunk step adds two
// divides and a second root. Sensor state resets to zero through one valid
// bit per sensor, so there is no clearing pass after reset. Configuration
// writes take effect at once and are meant for an idle block.
module position_step_speed_tracker_top
  #(
  parameter int NUM_SENSORS = pstk_pkg::NUM_SENSORS_DEF,
  parameter int FRAC_BITS   = pstk_pkg::FRAC_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [pstk_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pstk_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              in_kind,
  input  wire logic [pstk_pkg::SIDW-1:0]         in_sensor_id,
  input  wire logic signed [pstk_pkg::TW-1:0]    in_x_raw,
  input  wire logic signed [pstk_pkg::TW-1:0]    in_y_raw,
  input  wire logic signed [pstk_pkg::TW-1:0]    in_time_ms,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [pstk_pkg::SIDW-1:0]         out_sensor,
  output logic      [pstk_pkg::CW-1:0]           out_pos_x,
  output logic      [pstk_pkg::CW-1:0]           out_pos_y,
  output logic      [pstk_pkg::STEPW-1:0]        out_step_q8,
  output logic      [pstk_pkg::SPDW-1:0]         out_speed_q8,
  output logic      [pstk_pkg::TOTW-1:0]         out_total_q8,
  output logic                                   out_was_cropped,
  output logic                                   out_time_error
);
  import pstk_pkg::*;

  localparam int IDX_W = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int RTW   = 15 + FRAC_BITS;       // root / step width
  localparam int RW    = 2 * RTW;              // radicand width
  localparam int DVD_W = 24 + FRAC_BITS;       // divider dividend width
  localparam int DVS_W = 32;                   // divider divisor width
  localparam int ENT_W = 2 * CW + TW + TOTW;   // one RAM entry

  // Configuration registers.
  logic [CW-1:0]  coord_limit_r;
  logic [MSW-1:0] max_step_r;
  logic [SCW-1:0] speed_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coord_limit_r <= COORD_LIMIT_RST;
      max_step_r    <= MAX_STEP_RST;
      speed_scale_r <= SPEED_SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COORD_LIMIT: coord_limit_r <= cfg_wdata;
        CFG_MAX_STEP:    max_step_r    <= cfg_wdata[MSW-1:0];
        CFG_SPEED_SCALE: speed_scale_r <= cfg_wdata[SCW-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  state_t state_r, state_nxt;

  // Request fields, held for the whole request.
  logic              kind_r;
  logic [SIDW-1:0]   sid_r;
  logic [SIDW-1:0]   mod_r;
  logic [CW-1:0]     x_r, y_r;
  logic [TW-1:0]     t_r;

  // Working datapath.
  logic [TOTW-1:0]   ltot_r;
  logic [CW-1:0]     ma_r, mb_r;
  logic              negx_r, negy_r;
  logic [2*CW-1:0]   p_r;
  logic [SQ_W-1:0]   sq_r;
  logic [2*MSW-1:0]  mm_r;
  logic [RTW-1:0]    dist_r;
  logic              phase_r;
  logic [RTW-1:0]    step_r;
  logic [TW:0]       el_r;
  logic [DVD_W-1:0]  num_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [SPDW-1:0]   speed_r;
  logic [TOTW-1:0]   tot_r;
  logic              crop_r, terr_r;

  // Per-sensor valid bits stand in for clearing the RAM at reset.
  logic [NUM_SENSORS-1:0] vld_r;
  logic                   rdv_r;

  // Output register.
  logic              out_valid_r;

  // Sequencer controls.
  logic              ram_we;
  logic              sqrt_start;
  logic              div_start;

  // Unit and RAM wiring.
  logic [IDX_W-1:0]  idx;
  logic [ENT_W-1:0]  ram_rdata;
  logic [ENT_W-1:0]  ent;
  logic [CW-1:0]     ent_x, ent_y;
  logic [TW-1:0]     ent_t;
  logic [TOTW-1:0]   ent_tot;
  logic [RW-1:0]     rad;
  logic              sqrt_done;
  logic [RTW-1:0]    sqrt_root;
  logic              div_done;
  logic [DVD_W-1:0]  div_quo;
  logic              div_rem_nz;

  // Arithmetic.
  logic [CW:0]       dxs, dys;
  logic [TW:0]       el_w;
  logic [2*CW-1:0]   sqa, sqb;
  logic [2*MSW-1:0]  mm_w;
  logic [CW-1:0]     msel;
  logic [CW+MSW-1:0] sh_prod;
  logic [RTW+SCW-1:0] spd_prod;
  logic [DVD_W-1:0]  qadj;
  logic              qneg;
  logic [TOTW:0]     tsum;
  logic              mod_hi;

  assign idx     = IDX_W'(mod_r);
  assign mod_hi  = {5'd0, mod_r} >= 9'(NUM_SENSORS);
  assign ent     = rdv_r ? ram_rdata : '0;
  assign {ent_x, ent_y, ent_t, ent_tot} = ent;

  assign dxs     = {1'b0, x_r} - {1'b0, ent_x};
  assign dys     = {1'b0, y_r} - {1'b0, ent_y};
  assign el_w    = {t_r[TW-1], t_r} - {ent_t[TW-1], ent_t};
  assign sqa     = ma_r * ma_r;
  assign sqb     = mb_r * mb_r;
  assign mm_w    = max_step_r * max_step_r;
  assign msel    = (state_r == ST_NUMY) ? mb_r : ma_r;
  assign sh_prod = msel * max_step_r;
  assign spd_prod = step_r * speed_scale_r;
  assign rad     = {1'b0, sq_r, {(2*FRAC_BITS){1'b0}}};
  // Negative offsets round toward minus infinity: bump the magnitude.
  assign qneg    = (state_r == ST_DVYW) ? negy_r : negx_r;
  assign qadj    = div_quo + DVD_W'(qneg & div_rem_nz);
  assign tsum    = {1'b0, ltot_r} + (TOTW+1)'(step_r);

  pstk_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SENSORS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx),
    .wdata ({x_r, y_r, t_r, tot_r}),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  pstk_sqrt #(
    .RW (RW)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (rad),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  pstk_div #(
    .DW (DVD_W),
    .SW (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (num_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quo      (div_quo),
    .rem_nz   (div_rem_nz)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_MOD;
      ST_MOD:  if (!mod_hi) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = kind_r ? ST_SQA : ST_WB;
      ST_SQA:  state_nxt = ST_SQB;
      ST_SQB:  state_nxt = ST_RTS;
      ST_RTS:  state_nxt = ST_RTW;
      ST_RTW: begin
        if (sqrt_done) begin
          if (!phase_r && (sq_r > SQ_W'(mm_r))) state_nxt = ST_NUMX;
          else state_nxt = ST_SPD;
        end
      end
      ST_NUMX: state_nxt = ST_DVXS;
      ST_DVXS: state_nxt = ST_DVXW;
      ST_DVXW: if (div_done) state_nxt = ST_NUMY;
      ST_NUMY: state_nxt = ST_DVYS;
      ST_DVYS: state_nxt = ST_DVYW;
      ST_DVYW: if (div_done) state_nxt = ST_SQA;
      ST_SPD: begin
        if (step_r == '0 || el_r[TW] || el_r == '0) state_nxt = ST_TOT;
        else state_nxt = ST_SPM;
      end
      ST_SPM:  state_nxt = ST_SPS;
      ST_SPS:  state_nxt = ST_SPW;
      ST_SPW:  if (div_done) state_nxt = ST_TOT;
      ST_TOT:  state_nxt = ST_WB;
      ST_WB:   state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready   = 1'b1;
      ST_RTS:  sqrt_start = 1'b1;
      ST_DVXS: div_start  = 1'b1;
      ST_DVYS: div_start  = 1'b1;
      ST_SPS:  div_start  = 1'b1;
      ST_WB:   ram_we     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ram_we) begin
        vld_r[idx] <= 1'b1;
      end
      if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers, advanced by the sequencer state.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        // Latch the request and clamp the point.
        kind_r <= in_kind;
        sid_r  <= in_sensor_id;
        mod_r  <= in_sensor_id;
        x_r    <= clamp_coord(in_x_raw, coord_limit_r);
        y_r    <= clamp_coord(in_y_raw, coord_limit_r);
        t_r    <= in_time_ms;
      end
      ST_MOD: begin
        // Wrap the sensor id into the table, one subtraction a cycle.
        if (mod_hi) mod_r <= mod_r - SIDW'(NUM_SENSORS);
      end
      ST_RD: rdv_r <= vld_r[idx];
      ST_LOAD: begin
        ltot_r  <= ent_tot;
        tot_r   <= ent_tot;
        negx_r  <= dxs[CW];
        negy_r  <= dys[CW];
        ma_r    <= dxs[CW] ? CW'(-dxs) : dxs[CW-1:0];
        mb_r    <= dys[CW] ? CW'(-dys) : dys[CW-1:0];
        el_r    <= el_w;
        step_r  <= '0;
        speed_r <= '0;
        crop_r  <= 1'b0;
        terr_r  <= 1'b0;
        phase_r <= 1'b0;
      end
      ST_SQA: begin
        p_r  <= sqa;
        mm_r <= mm_w;
      end
      ST_SQB: sq_r <= SQ_W'(p_r) + SQ_W'(sqb);
      ST_RTW: begin
        if (sqrt_done) begin
          dist_r <= sqrt_root;
          step_r <= sqrt_root;
          if (!phase_r && (sq_r > SQ_W'(mm_r))) crop_r <= 1'b1;
        end
      end
      ST_NUMX, ST_NUMY: begin
        num_r <= {sh_prod, {FRAC_BITS{1'b0}}};
        dvs_r <= DVS_W'(dist_r);
      end
      ST_DVXW: if (div_done) ma_r <= qadj[CW-1:0];
      ST_DVYW: begin
        if (div_done) begin
          mb_r    <= qadj[CW-1:0];
          phase_r <= 1'b1;
        end
      end
      ST_SPD: begin
        // Nonzero step with zero or negative elapsed time: flag and saturate.
        if (step_r != '0 && (el_r[TW] || el_r == '0)) begin
          terr_r  <= 1'b1;
          speed_r <= SPEED_MAX;
        end
      end
      ST_SPM: begin
        num_r <= DVD_W'(spd_prod);
        dvs_r <= el_r[DVS_W-1:0];
      end
      ST_SPW: begin
        if (div_done) begin
          speed_r <= (div_quo > DVD_W'(SPEED_MAX)) ? SPEED_MAX : div_quo[SPDW-1:0];
        end
      end
      ST_TOT: tot_r <= tsum[TOTW] ? TOTAL_MAX : tsum[TOTW-1:0];
      default: ;
    endcase
  end

  // Result register: load once the previous result has left.
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_ready)) begin
      out_sensor      <= sid_r;
      out_pos_x       <= x_r;
      out_pos_y       <= y_r;
      out_step_q8     <= STEPW'(step_r);
      out_speed_q8    <= speed_r;
      out_total_q8    <= tot_r;
      out_was_cropped <= crop_r;
      out_time_error  <= terr_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire
